>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the track/sector mapper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ZD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ZD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/zdts_pkg.sv
// ----------------------------------------------------------------------------
// zdts_pkg
// Types, format codes and zone tables of the zoned disk track/sector mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zdts_pkg;

    // Disk format codes held in the format register.
    localparam logic [3:0] FMT_1541 = 4'd0;
    localparam logic [3:0] FMT_2040 = 4'd1;
    localparam logic [3:0] FMT_1571 = 4'd2;
    localparam logic [3:0] FMT_8050 = 4'd3;
    localparam logic [3:0] FMT_8250 = 4'd4;
    localparam logic [3:0] FMT_1581 = 4'd5;
    localparam logic [3:0] FMT_1000 = 4'd6;
    localparam logic [3:0] FMT_2000 = 4'd7;
    localparam logic [3:0] FMT_4000 = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISK_FORMAT = 2'd0;
    localparam logic [1:0] REG_TRACK_LIMIT = 2'd1;

    localparam logic [3:0] FORMAT_RESET = FMT_1541;
    localparam logic [7:0] LIMIT_RESET  = 8'd42;

    // Tracks on one side of the double-sided formats.
    localparam logic [7:0] SIDE_TRACKS_1571 = 8'd35;
    localparam logic [7:0] SIDE_TRACKS_8250 = 8'd77;

    localparam logic [8:0] SPT_1581      = 9'd40;
    localparam logic [8:0] SPT_HALF      = 9'd128;
    localparam logic [8:0] SPT_FULL      = 9'd256;

    localparam logic [4:0]  SPT_1541 [0:3] = '{5'd17, 5'd18, 5'd19, 5'd21};
    localparam logic [4:0]  SPT_2040 [0:3] = '{5'd17, 5'd18, 5'd20, 5'd21};
    localparam logic [4:0]  SPT_8050 [0:3] = '{5'd23, 5'd25, 5'd27, 5'd29};
    localparam logic [12:0] GCR_LEN  [0:3] = '{13'd6250, 13'd6666, 13'd7142, 13'd7692};
    localparam logic [4:0]  GAP_LEN  [0:3] = '{5'd9, 5'd12, 5'd17, 5'd8};

    typedef struct packed {
        logic [7:0] track_number;
        logic [7:0] sector_number;
    } request_t;

    typedef struct packed {
        logic        in_range;
        logic [15:0] block_index;
        logic [8:0]  sectors_in_track;
        logic [1:0]  speed_zone;
        logic [12:0] raw_track_bytes;
        logic [4:0]  gap_bytes;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SUM,
        ST_DONE
    } state_t;

    // Control from the sequencer to the accumulator.
    typedef struct packed {
        logic load;
        logic add;
    } acc_ctrl_t;

    // Speed zone of a low-density (1541 style) track.
    function automatic logic [1:0] zone_low(input logic [7:0] t);
        logic [1:0] z;
        if (t < 8'd18)      z = 2'd3;
        else if (t < 8'd25) z = 2'd2;
        else if (t < 8'd31) z = 2'd1;
        else                z = 2'd0;
        return z;
    endfunction

    // Speed zone of a high-density (8050 style) track.
    function automatic logic [1:0] zone_high(input logic [7:0] t);
        logic [1:0] z;
        if (t < 8'd40)      z = 2'd3;
        else if (t < 8'd54) z = 2'd2;
        else if (t < 8'd65) z = 2'd1;
        else                z = 2'd0;
        return z;
    endfunction

endpackage

>>> src/zoned_disk_track_sector_to_block_unit.sv
// ----------------------------------------------------------------------------
// zoned_disk_track_sector_to_block_unit
// Maps a track and sector of a zoned-recording disk to a linear block index.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                              Direction  Handshake
//   request   start, busy, request                 in         start && !busy
//   result    done, result                         out        done strobe
//   config    cfg_valid, cfg_ready, cfg_index,     in         valid && ready
//             cfg_data
//
// A transaction passes from the start cycle in idle through the count state,
// which looks up the requested track, and the sum state, which adds each
// earlier track through the shared sectors-per-track lookup and
// accumulator, to the done state with the result; the sum state is skipped
// when the sector is out of range or the track is 1. busy is high from the
// cycle after a start until the result strobe cycle ends. The result is
// valid on the result port in the one cycle in which done is high; the
// receiver cannot stall it. Reset returns the sequencer to idle and loads
// the format register with 1541 and the track limit with 42. Configuration
// writes are always accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module zoned_disk_track_sector_to_block_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  zdts_pkg::request_t request,
    output logic               done,
    output zdts_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import zdts_pkg::*;

    // Configuration registers.
    logic [3:0] format_reg;
    logic [7:0] limit_reg;

    // Sequencer state and the captured request.
    state_t     state_reg;
    state_t     state_next;
    logic [7:0] track_reg;
    logic [7:0] sector_reg;
    logic [7:0] iter_reg;
    logic [7:0] iter_next;
    logic [8:0] count_reg;
    logic       ok_reg;

    // Shared lookup and accumulator.
    logic [7:0]  lookup_track;
    logic [8:0]  lookup_sectors;
    acc_ctrl_t   acc_ctrl;
    logic [15:0] acc_sum;
    logic        accept;
    logic        req_ok;
    logic [1:0]  zone;

    assign cfg_ready = 1'b1;
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FORMAT_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_DISK_FORMAT)
                format_reg <= cfg_data[3:0];
            else if (cfg_index == REG_TRACK_LIMIT)
                limit_reg <= cfg_data;
        end
    end

    // The lookup serves the requested track in the count cycle and the
    // running track counter while summing the earlier tracks.
    assign lookup_track = (state_reg == ST_SUM) ? iter_reg : track_reg;

    zdts_spt u_spt (
        .disk_format (format_reg),
        .track_limit (limit_reg),
        .track       (lookup_track),
        .sectors     (lookup_sectors)
    );

    zdts_acc u_acc (
        .clk        (clk),
        .ctrl       (acc_ctrl),
        .load_value (sector_reg),
        .addend     (lookup_sectors),
        .sum        (acc_sum)
    );

    assign req_ok = (track_reg != 8'd0) && ({1'b0, sector_reg} < lookup_sectors);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        acc_ctrl.load = 1'b0;
        acc_ctrl.add  = 1'b0;
        done          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                // The index starts at the sector number; tracks below the
                // requested one are added afterwards.
                acc_ctrl.load = 1'b1;
                iter_next     = 8'd1;
                if (req_ok && track_reg != 8'd1)
                    state_next = ST_SUM;
                else
                    state_next = ST_DONE;
            end
            ST_SUM:
            begin
                acc_ctrl.add = 1'b1;
                iter_next    = iter_reg + 8'd1;
                if (iter_next == track_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        if (accept)
        begin
            track_reg  <= request.track_number;
            sector_reg <= request.sector_number;
        end
        if (state_reg == ST_COUNT)
        begin
            count_reg <= lookup_sectors;
            ok_reg    <= req_ok;
        end
    end

    // The zone fields follow the track number alone, whatever the format.
    assign zone = zone_low(track_reg);

    always_comb
    begin
        result.in_range         = ok_reg;
        result.block_index      = ok_reg ? acc_sum : 16'd0;
        result.sectors_in_track = count_reg;
        result.speed_zone       = zone;
        result.raw_track_bytes  = GCR_LEN[zone];
        result.gap_bytes        = GAP_LEN[zone];
    end

    // An accepted request makes the unit busy on the next cycle.
    `ZD_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept did not raise busy")
    // The result strobe lasts exactly one cycle.
    `ZD_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "done held longer than one cycle")
    // A result out of range carries a zero index.
    `ZD_ASSERT(a_zero_index, clk, rst_n, (done && !result.in_range) |-> (result.block_index == 16'd0), "nonzero index out of range")
    // A track without sectors is never in range.
    `ZD_ASSERT(a_empty_track, clk, rst_n, (done && result.sectors_in_track == 9'd0) |-> !result.in_range, "in range on empty track")

endmodule

>>> src/zdts_spt.sv
// ----------------------------------------------------------------------------
// zdts_spt
// Sectors-per-track lookup for the configured disk format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zdts_spt (
    input  logic [3:0] disk_format,
    input  logic [7:0] track_limit,
    input  logic [7:0] track,
    output logic [8:0] sectors
);
    import zdts_pkg::*;

    logic [7:0] fold_1571;
    logic [7:0] fold_8250;

    assign fold_1571 = (track > SIDE_TRACKS_1571) ? track - SIDE_TRACKS_1571 : track;
    assign fold_8250 = (track > SIDE_TRACKS_8250) ? track - SIDE_TRACKS_8250 : track;

    always_comb
    begin
        if (track == 8'd0 || track > track_limit)
        begin
            sectors = '0;
        end
        else
        begin
            unique case (disk_format)
                FMT_1541: sectors = {4'd0, SPT_1541[zone_low(track)]};
                FMT_2040: sectors = {4'd0, SPT_2040[zone_low(track)]};
                FMT_1571: sectors = {4'd0, SPT_1541[zone_low(fold_1571)]};
                FMT_8050: sectors = {4'd0, SPT_8050[zone_high(track)]};
                FMT_8250: sectors = {4'd0, SPT_8050[zone_high(fold_8250)]};
                FMT_1581: sectors = SPT_1581;
                FMT_1000: sectors = (track == track_limit) ? SPT_HALF : SPT_FULL;
                FMT_2000: sectors = SPT_FULL;
                FMT_4000: sectors = SPT_FULL;
                default:  sectors = '0;
            endcase
        end
    end

endmodule

>>> src/zdts_acc.sv
// ----------------------------------------------------------------------------
// zdts_acc
// Block index accumulator: loads the sector number, then adds track sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zdts_acc (
    input  logic                 clk,
    input  zdts_pkg::acc_ctrl_t  ctrl,
    input  logic [7:0]           load_value,
    input  logic [8:0]           addend,
    output logic [15:0]          sum
);
    import zdts_pkg::*;

    logic [15:0] sum_reg;
    logic [15:0] sum_next;

    always_comb
    begin
        priority if (ctrl.load)
            sum_next = {8'd0, load_value};
        else if (ctrl.add)
            sum_next = sum_reg + {7'd0, addend};
        else
            sum_next = sum_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

>>> verif/zdts_result_checker.sv
// ----------------------------------------------------------------------------
// zdts_result_checker
// Watches the request, result and register channels of the track/sector
// mapper, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zdts_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  zdts_pkg::request_t request,
    input  logic               done,
    input  zdts_pkg::result_t  result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    import zdts_pkg::*;

    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] LIMIT_AFTER_RESET = 8'd42;
    localparam logic [7:0] FOLD_1571 = 8'd35;
    localparam logic [7:0] FOLD_8250 = 8'd77;
    localparam logic [8:0] SECTORS_1581 = 9'd40;
    localparam logic [8:0] SECTORS_HALF = 9'd128;
    localparam logic [8:0] SECTORS_FULL = 9'd256;

    // Per-zone tables, zone 0 in the lowest slot.
    localparam logic [3:0][8:0]  ZONE_SECTORS_1541 = {9'd21, 9'd19, 9'd18, 9'd17};
    localparam logic [3:0][8:0]  ZONE_SECTORS_2040 = {9'd21, 9'd20, 9'd18, 9'd17};
    localparam logic [3:0][8:0]  ZONE_SECTORS_8050 = {9'd29, 9'd27, 9'd25, 9'd23};
    localparam logic [3:0][12:0] ZONE_RAW_BYTES = {13'd7692, 13'd7142, 13'd6666, 13'd6250};
    localparam logic [3:0][4:0]  ZONE_GAP_BYTES = {5'd8, 5'd17, 5'd12, 5'd9};

    typedef struct packed {
        request_t req;
        result_t  res;
    } lookup_t;

    lookup_t    lookups_due[$];
    logic [3:0] format_q;
    logic [7:0] limit_q;

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic logic [1:0] low_density_zone(input logic [7:0] trk);
        if (trk >= 8'd31) return 2'd0;
        if (trk >= 8'd25) return 2'd1;
        if (trk >= 8'd18) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic [1:0] high_density_zone(input logic [7:0] trk);
        if (trk >= 8'd65) return 2'd0;
        if (trk >= 8'd54) return 2'd1;
        if (trk >= 8'd40) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic [8:0] track_sectors(input logic [7:0] trk,
                                                 input logic [3:0] fmt,
                                                 input logic [7:0] lim);
        if (trk == 8'd0 || trk > lim)
            return 9'd0;
        case (fmt)
            FMT_1541: return ZONE_SECTORS_1541[low_density_zone(trk)];
            FMT_2040: return ZONE_SECTORS_2040[low_density_zone(trk)];
            FMT_1571: return ZONE_SECTORS_1541[low_density_zone(
                                 (trk > FOLD_1571) ? trk - FOLD_1571 : trk)];
            FMT_8050: return ZONE_SECTORS_8050[high_density_zone(trk)];
            FMT_8250: return ZONE_SECTORS_8050[high_density_zone(
                                 (trk > FOLD_8250) ? trk - FOLD_8250 : trk)];
            FMT_1581: return SECTORS_1581;
            FMT_1000: return (trk == lim) ? SECTORS_HALF : SECTORS_FULL;
            FMT_2000, FMT_4000: return SECTORS_FULL;
            default: return 9'd0;
        endcase
    endfunction

    function automatic result_t map_to_block(input request_t req,
                                             input logic [3:0] fmt,
                                             input logic [7:0] lim);
        result_t    res;
        logic [8:0] count;
        logic [1:0] zone;
        int         total;
        logic [7:0] trk_i;
        count = track_sectors(req.track_number, fmt, lim);
        zone  = low_density_zone(req.track_number);
        res.in_range = (req.track_number != 8'd0) && ({1'b0, req.sector_number} < count);
        total = 0;
        if (res.in_range) begin
            total = req.sector_number;
            for (trk_i = 8'd1; trk_i < req.track_number; trk_i++)
                total += track_sectors(trk_i, fmt, lim);
        end
        res.block_index      = total[15:0];
        res.sectors_in_track = count;
        res.speed_zone       = zone;
        res.raw_track_bytes  = ZONE_RAW_BYTES[zone];
        res.gap_bytes        = ZONE_GAP_BYTES[zone];
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got, input request_t req);
        if (want != got) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: track %0d sector %0d: %s expected %0d, got %0d",
                         $time, req.track_number, req.sector_number, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lookup_t due;
        if (!rst_n) begin
            format_q = FMT_1541;
            limit_q  = LIMIT_AFTER_RESET;
            lookups_due.delete();
        end else begin
            if (done) begin
                if (lookups_due.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result with no request outstanding", $time);
                    mismatches++;
                end else begin
                    due = lookups_due.pop_front();
                    check_field("in_range", due.res.in_range, result.in_range, due.req);
                    check_field("block_index", due.res.block_index,
                                result.block_index, due.req);
                    check_field("sectors_in_track", due.res.sectors_in_track,
                                result.sectors_in_track, due.req);
                    check_field("speed_zone", due.res.speed_zone,
                                result.speed_zone, due.req);
                    check_field("raw_track_bytes", due.res.raw_track_bytes,
                                result.raw_track_bytes, due.req);
                    check_field("gap_bytes", due.res.gap_bytes,
                                result.gap_bytes, due.req);
                end
            end
            if (start && !busy) begin
                due.req = request;
                due.res = map_to_block(request, format_q, limit_q);
                lookups_due.push_back(due);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DISK_FORMAT: format_q = cfg_data[3:0];
                    REG_TRACK_LIMIT: limit_q  = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = lookups_due.size();
    end

endmodule

>>> verif/zoned_disk_track_sector_to_block_unit_tb.sv
// ----------------------------------------------------------------------------
// zoned_disk_track_sector_to_block_unit_tb
// Drives track/sector lookups through the zoned disk mapper under a series of
// format and track-limit settings; a separate checker predicts each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zoned_disk_track_sector_to_block_unit_tb;

    import zdts_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // The limit leaves several times the slowest legal run, with every lookup
    // at its longest plus the gaps.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // This outlasts the longest lookup, so it covers any late strobe.
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_COUNT  = 16;
    localparam int MAX_GAP      = 8;

    // Indexes that decode to no register; writes there must change nothing.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    // Format codes beyond the last defined format.
    localparam logic [3:0] FMT_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] FMT_UNKNOWN_HI = 4'd15;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    request_t   request = '0;
    logic       done;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_DISK_FORMAT;
    logic [7:0] cfg_data = 8'd0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // Stimulus-side view of the current limit, used only to shape requests.
    logic [7:0] cur_limit = 8'd42;

    // Remaining transactions in a back-to-back stretch without any gap.
    int no_gap_run = 0;

    always #CLK_HALF clk = ~clk;

    zoned_disk_track_sector_to_block_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zdts_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Gap before the next transaction. Mostly a random gap up to MAX_GAP, but now
    // and then a stretch of back-to-back transactions with no gap at all.
    function automatic int draw_gap();
        if (no_gap_run > 0) begin
            no_gap_run--;
            return 0;
        end
        if ($urandom_range(15, 0) == 0)
            no_gap_run = $urandom_range(20, 5);
        return $urandom_range(MAX_GAP, 0);
    endfunction

    // Every task below is entered and left at a falling edge. A valid that
    // carries straight into the next transaction is left high on return, so
    // it is never lowered and raised again within one time step.
    task automatic issue_lookup(input logic [7:0] trk, input logic [7:0] sec);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start                 <= 1'b1;
        request.track_number  <= trk;
        request.sector_number <= sec;
        // The transaction is taken at the first rising edge with busy low.
        do @(posedge clk); while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drops both valids, then waits until every lookup has reported and the
    // block has left its busy state, so registers change only while idle.
    task automatic wait_idle();
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        while (outstanding != 0 || busy !== 1'b0)
            @(negedge clk);
    endtask

    task automatic set_config(input logic [3:0] fmt, input logic [7:0] lim);
        wait_idle();
        // The upper nibble of a format write is junk that must be ignored.
        write_reg(REG_DISK_FORMAT, {4'($urandom_range(15, 0)), fmt});
        if ($urandom_range(2, 0) == 0)
            write_reg(($urandom_range(1, 0) != 0) ? REG_SPARE_A : REG_SPARE_B,
                      8'($urandom_range(255, 0)));
        write_reg(REG_TRACK_LIMIT, lim);
        cfg_valid <= 1'b0;
        cur_limit  = lim;
    endtask

    // Track count usually loaded for each format; unknown codes get a random one.
    function automatic logic [7:0] usual_limit(input logic [3:0] fmt);
        case (fmt)
            FMT_1541: return ($urandom_range(1, 0) != 0) ? 8'd35 : 8'd40;
            FMT_2040: return 8'd35;
            FMT_1571: return 8'd70;
            FMT_8050: return 8'd77;
            FMT_8250: return 8'd154;
            FMT_1581: return 8'd80;
            FMT_1000: return 8'd81;
            FMT_2000: return 8'd81;
            FMT_4000: return 8'd162;
            default:  return 8'($urandom_range(255, 1));
        endcase
    endfunction

    // Most lookups name a track that exists, and half name a sector low enough to be
    // in range on any zoned format; the rest roam the whole field range.
    task automatic random_lookup();
        logic [7:0] trk;
        logic [7:0] sec;
        if (cur_limit != 8'd0 && $urandom_range(3, 0) != 0)
            trk = 8'($urandom_range(cur_limit, 1));
        else
            trk = 8'($urandom_range(255, 0));
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4: sec = 8'($urandom_range(16, 0));
            5, 6:          sec = 8'($urandom_range(40, 0));
            default:       sec = 8'($urandom_range(255, 0));
        endcase
        issue_lookup(trk, sec);
    endtask

    initial begin
        logic [3:0] fmt;
        logic [7:0] lim;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. First under the reset setting (1541, limit 42):
        // track zero, zone edges, the last sector of a track and one past
        // it, the last legal track, one past the limit, and field extremes.
        issue_lookup(8'd0, 8'd0);
        issue_lookup(8'd1, 8'd0);
        issue_lookup(8'd1, 8'd20);
        issue_lookup(8'd1, 8'd21);
        issue_lookup(8'd17, 8'd20);
        issue_lookup(8'd18, 8'd18);
        issue_lookup(8'd24, 8'd19);
        issue_lookup(8'd25, 8'd17);
        issue_lookup(8'd31, 8'd16);
        issue_lookup(8'd42, 8'd16);
        issue_lookup(8'd43, 8'd0);
        issue_lookup(8'd255, 8'd255);
        issue_lookup(8'd0, 8'd255);

        // Folded second side on the 1571: track 36 takes the zone of track 1.
        set_config(FMT_1571, 8'd70);
        issue_lookup(8'd36, 8'd20);
        issue_lookup(8'd70, 8'd16);
        issue_lookup(8'd71, 8'd0);

        // Folded second side on the 8250, plus the high-density zone edges.
        set_config(FMT_8250, 8'd154);
        issue_lookup(8'd39, 8'd28);
        issue_lookup(8'd78, 8'd28);
        issue_lookup(8'd154, 8'd22);

        // Half track at the limit on the 1000 format.
        set_config(FMT_1000, 8'd10);
        issue_lookup(8'd10, 8'd127);
        issue_lookup(8'd10, 8'd128);
        issue_lookup(8'd9, 8'd255);

        // A limit of zero puts every track over the limit.
        set_config(FMT_2000, 8'd0);
        issue_lookup(8'd1, 8'd0);

        // An unknown format has no tracks at all.
        set_config(FMT_UNKNOWN_HI, 8'd255);
        issue_lookup(8'd1, 8'd0);

        // Random part: every defined format once, then unknown and random
        // codes; the limit cycles through the usual value, random values
        // and both extremes.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase <= 8)
                fmt = 4'(phase);
            else if (phase == 9)
                fmt = FMT_UNKNOWN_LO;
            else if (phase == 10)
                fmt = FMT_UNKNOWN_HI;
            else
                fmt = 4'($urandom_range(FMT_UNKNOWN_HI, 0));
            case (phase % 4)
                0:       lim = usual_limit(fmt);
                1:       lim = 8'($urandom_range(255, 1));
                2:       lim = ($urandom_range(1, 0) != 0) ? 8'd255 : usual_limit(fmt);
                default: lim = 8'($urandom_range(60, 0));
            endcase
            if (phase == 12)
                lim = 8'd0;
            else if (phase == 13)
                lim = 8'd1;
            set_config(fmt, lim);
            repeat (RANDOM_ITEMS / PHASE_COUNT) random_lookup();
        end

        // Wind down: all results in, then a quiet spell to catch strays.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
